>>> rtl/pmul_pkg.sv
package pmul_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int COEF_WIDTH = 64;
    localparam int FIELD_W    = 64;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int IW    = $clog2(2 * MAX_TERMS);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [AW-1:0]         addr_t;
    typedef logic [IW-1:0]         idx_t;
    typedef logic [COEF_WIDTH-1:0] coef_t;

    typedef enum logic
    {
        OPERAND_FIRST  = 1'b0,
        OPERAND_SECOND = 1'b1
    } operand_t;

    typedef struct packed
    {
        logic                      operand_select;
        logic signed [FIELD_W-1:0] coefficient;
        logic                      last_term;
    } in_word_t;

    typedef struct packed
    {
        logic signed [FIELD_W-1:0] product_coefficient;
        logic                      last_result;
        logic                      truncated;
    } out_word_t;

    typedef struct packed
    {
        logic     store_en;
        operand_t operand;
        addr_t    addr;
        coef_t    value;
        logic     run_en;
        cnt_t     first_count;
        cnt_t     second_count;
        logic     truncated;
    } cmd_t;

endpackage

>>> rtl/polynomial_multiply.sv
// channel  | handshake            | word
// ---------+----------------------+------------------------------------------------
// item     | push / full          | operand_select, coefficient, last_term
// result   | pop / empty          | product_coefficient, last_result, truncated
//
// Each stored coefficient is written to its store when the idle back end pops it.
// A product of na by nb terms sends na*nb terms down the single multiply-accumulate
// pipeline, one term per cycle except while a result's last term is held back.
// Reset clears counts, flags and both queues; the coefficient stores are not cleared.
// full rises while both slots of the two-word command queue are taken; the back end
// holds the last term of a result while four result words are waiting or in flight.
module polynomial_multiply
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  pmul_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output pmul_pkg::out_word_t result
);
    import pmul_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;

    pmul_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (cmd_in)
    );

    pmul_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    pmul_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> rtl/pmul_front.sv
module pmul_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pmul_pkg::in_word_t item,
    output logic              cmd_push,
    input  logic              cmd_full,
    output pmul_pkg::cmd_t    cmd
);
    import pmul_pkg::*;

    cnt_t a_cnt_reg, a_cnt_next;
    cnt_t b_cnt_reg, b_cnt_next;
    logic a_done_reg, a_done_next;
    logic b_done_reg, b_done_next;
    logic ovf_reg, ovf_next;
    logic accept;
    logic store;
    logic run;
    cnt_t cur_cnt;
    logic cur_done;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        cur_cnt     = item.operand_select ? b_cnt_reg : a_cnt_reg;
        cur_done    = item.operand_select ? b_done_reg : a_done_reg;
        a_cnt_next  = a_cnt_reg;
        b_cnt_next  = b_cnt_reg;
        a_done_next = a_done_reg;
        b_done_next = b_done_reg;
        ovf_next    = ovf_reg;
        store       = 1'b0;
        if (!cur_done)
        begin
            if (cur_cnt < CNT_W'(MAX_TERMS))
            begin
                store = 1'b1;
                if (item.operand_select)
                    b_cnt_next = b_cnt_reg + CNT_W'(1);
                else
                    a_cnt_next = a_cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (item.last_term)
            begin
                if (item.operand_select)
                    b_done_next = 1'b1;
                else
                    a_done_next = 1'b1;
            end
        end
        run = a_done_next && b_done_next;

        cmd.store_en     = store;
        cmd.operand      = item.operand_select ? OPERAND_SECOND : OPERAND_FIRST;
        cmd.addr         = cur_cnt[AW-1:0];
        cmd.value        = item.coefficient[COEF_WIDTH-1:0];
        cmd.run_en       = run;
        cmd.first_count  = a_cnt_next;
        cmd.second_count = b_cnt_next;
        cmd.truncated    = ovf_next;

        if (run)
        begin
            a_cnt_next  = '0;
            b_cnt_next  = '0;
            a_done_next = 1'b0;
            b_done_next = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    assign cmd_push = accept && (store || run);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg  <= '0;
            b_cnt_reg  <= '0;
            a_done_reg <= 1'b0;
            b_done_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            a_cnt_reg  <= a_cnt_next;
            b_cnt_reg  <= b_cnt_next;
            a_done_reg <= a_done_next;
            b_done_reg <= b_done_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

>>> rtl/pmul_cmd_queue.sv
module pmul_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pmul_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output pmul_pkg::cmd_t rd_data,
    output logic           empty
);
    import pmul_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

>>> rtl/pmul_back.sv
module pmul_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  pmul_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output pmul_pkg::out_word_t result
);
    import pmul_pkg::*;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    coef_t mem_a [MAX_TERMS];
    coef_t mem_b [MAX_TERMS];

    state_t state_reg;
    idx_t   i_reg;
    addr_t  j_reg;
    idx_t   last_i_reg;
    cnt_t   na_reg;
    cnt_t   nb_reg;
    logic   trunc_reg;
    logic   first_pend_reg;

    idx_t   na_m1;
    idx_t   j_hi;
    logic   j_at_hi;
    idx_t   k_full;
    addr_t  k_addr;
    idx_t   ip1;
    idx_t   j_lo_full;
    logic   issue;

    coef_t  rd_a_reg;
    coef_t  rd_b_reg;
    logic   s1_v_reg, s1_first_reg, s1_last_reg, s1_lr_reg, s1_tr_reg;

    logic [63:0] a_ext, b_ext;
    logic [63:0] p_ll_reg;
    logic [31:0] p_lh_reg, p_hl_reg;
    logic        s2_v_reg, s2_first_reg, s2_last_reg, s2_lr_reg, s2_tr_reg;

    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] acc_reg;

    out_word_t        oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_cnt_reg;
    logic [OQ_CW-1:0] res_reg;
    logic             oq_wr;
    logic             oq_rd;
    logic             res_inc;
    out_word_t        oq_in;

    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;

    always_comb
    begin
        na_m1   = IW'(na_reg) - IW'(1);
        j_hi    = (i_reg < na_m1) ? i_reg : na_m1;
        j_at_hi = (IW'(j_reg) == j_hi);
        k_full  = i_reg - IW'(j_reg);
        k_addr  = k_full[AW-1:0];
        ip1     = i_reg + IW'(1);
        if (ip1 >= IW'(nb_reg))
            j_lo_full = ip1 - IW'(nb_reg) + IW'(1);
        else
            j_lo_full = '0;
        issue = (state_reg == ST_RUN) && (!j_at_hi || (res_reg < OQ_CW'(OQ_DEPTH)));
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.store_en && (cmd.operand == OPERAND_FIRST))
            mem_a[cmd.addr] <= cmd.value;
        rd_a_reg <= mem_a[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.store_en && (cmd.operand == OPERAND_SECOND))
            mem_b[cmd.addr] <= cmd.value;
        rd_b_reg <= mem_b[k_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            last_i_reg     <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
            trunc_reg      <= 1'b0;
            first_pend_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop && cmd.run_en)
                    begin
                        state_reg      <= ST_RUN;
                        i_reg          <= '0;
                        j_reg          <= '0;
                        na_reg         <= cmd.first_count;
                        nb_reg         <= cmd.second_count;
                        last_i_reg     <= IW'(cmd.first_count) + IW'(cmd.second_count)
                                          - IW'(2);
                        trunc_reg      <= cmd.truncated;
                        first_pend_reg <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        if (j_at_hi)
                        begin
                            first_pend_reg <= 1'b1;
                            if (i_reg == last_i_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                i_reg <= ip1;
                                j_reg <= j_lo_full[AW-1:0];
                            end
                        end
                        else
                        begin
                            first_pend_reg <= 1'b0;
                            j_reg          <= j_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    assign a_ext = 64'(rd_a_reg);
    assign b_ext = 64'(rd_b_reg);

    always_ff @(posedge clk)
    begin
        s1_first_reg <= first_pend_reg;
        s1_last_reg  <= j_at_hi;
        s1_lr_reg    <= (i_reg == last_i_reg);
        s1_tr_reg    <= trunc_reg;

        p_ll_reg     <= a_ext[31:0] * b_ext[31:0];
        p_lh_reg     <= a_ext[31:0] * b_ext[63:32];
        p_hl_reg     <= a_ext[63:32] * b_ext[31:0];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_lr_reg    <= s1_lr_reg;
        s2_tr_reg    <= s1_tr_reg;

        if (s2_v_reg)
            acc_reg <= sum;
    end

    always_comb
    begin
        prod = p_ll_reg + {p_lh_reg + p_hl_reg, 32'd0};
        sum  = s2_first_reg ? prod : (acc_reg + prod);
        oq_in.product_coefficient = FIELD_W'($signed(sum[COEF_WIDTH-1:0]));
        oq_in.last_result         = s2_lr_reg;
        oq_in.truncated           = s2_tr_reg;
    end

    assign oq_wr   = s2_v_reg && s2_last_reg;
    assign empty   = (oq_cnt_reg == '0);
    assign oq_rd   = pop && !empty;
    assign result  = oq_mem[oq_rd_reg];
    assign res_inc = issue && j_at_hi;

    always_ff @(posedge clk)
    begin
        if (oq_wr)
            oq_mem[oq_wr_reg] <= oq_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            if (oq_wr)
                oq_wr_reg <= oq_wr_reg + OQ_AW'(1);
            if (oq_rd)
                oq_rd_reg <= oq_rd_reg + OQ_AW'(1);
            oq_cnt_reg <= oq_cnt_reg + OQ_CW'(oq_wr) - OQ_CW'(oq_rd);
            res_reg    <= res_reg + OQ_CW'(res_inc) - OQ_CW'(oq_rd);
        end
    end

endmodule

>>> sim/pmul_scoreboard_pkg.sv
package pmul_scoreboard_pkg;

    import pmul_pkg::*;

    class product_scoreboard;

        coef_t     store[2][MAX_TERMS];
        int        count[2];
        bit        complete[2];
        bit        dropped;
        out_word_t expected_products[$];
        int        mismatches;

        function new();
            count[0]   = 0;
            count[1]   = 0;
            complete[0] = 1'b0;
            complete[1] = 1'b0;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        function void note_coefficient(in_word_t w);
            int        side;
            int        total;
            int        k;
            coef_t     acc;
            out_word_t r;
            side = w.operand_select;
            if (!complete[side])
            begin
                if (count[side] < MAX_TERMS)
                begin
                    store[side][count[side]] = w.coefficient[COEF_WIDTH-1:0];
                    count[side]++;
                end
                else
                begin
                    dropped = 1'b1;
                end
                if (w.last_term)
                    complete[side] = 1'b1;
            end
            if (!(complete[OPERAND_FIRST] && complete[OPERAND_SECOND]))
                return;
            total = count[OPERAND_FIRST] + count[OPERAND_SECOND] - 1;
            for (int i = 0; i < total; i++)
            begin
                acc = '0;
                for (int j = 0; j < count[OPERAND_FIRST] && j <= i; j++)
                begin
                    k = i - j;
                    if (k < count[OPERAND_SECOND])
                        acc += store[OPERAND_FIRST][j] * store[OPERAND_SECOND][k];
                end
                r.product_coefficient = $signed(acc);
                r.last_result         = (i + 1 == total);
                r.truncated           = dropped;
                expected_products.push_back(r);
            end
            count[0]    = 0;
            count[1]    = 0;
            complete[0] = 1'b0;
            complete[1] = 1'b0;
            dropped     = 1'b0;
        endfunction

        function void check_product(out_word_t r);
            out_word_t e;
            if (expected_products.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: coef=%0d last=%0b trunc=%0b",
                             r.product_coefficient, r.last_result, r.truncated);
                return;
            end
            e = expected_products.pop_front();
            if (r.product_coefficient !== e.product_coefficient ||
                r.last_result !== e.last_result || r.truncated !== e.truncated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch coef/last/trunc: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             e.product_coefficient, e.last_result, e.truncated,
                             r.product_coefficient, r.last_result, r.truncated);
            end
        endfunction

        function int pending();
            return expected_products.size();
        endfunction

    endclass

endpackage

>>> sim/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pmul_pkg::*;
    import pmul_scoreboard_pkg::*;

    localparam logic signed [63:0] COEF_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] COEF_MAX = 64'sh7fff_ffff_ffff_ffff;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    product_scoreboard sb;
    bit  steady;
    int  counted;
    int  hold;

    polynomial_multiply DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 10);
        if (r < 93)
            return $urandom_range(11, 16);
        return $urandom_range(17, 19);
    endfunction

    function automatic logic signed [63:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return 64'sd0;
            3: return -64'sd1;
            4: return $signed(64'($urandom_range(0, 20))) - 64'sd10;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic in_word_t make_word(operand_t op, logic signed [63:0] c, logic last);
        in_word_t w;
        w.operand_select = op;
        w.coefficient    = c;
        w.last_term      = last;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge clk);
        push = 1'b1;
        item = w;
        do
            @(posedge clk);
        while (full);
        sb.note_coefficient(w);
        counted++;
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic run_pair(input int na, input int nb);
        int       ia;
        int       ib;
        operand_t op;
        logic     last;
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if (ia >= na)
                op = OPERAND_SECOND;
            else if (ib >= nb)
                op = OPERAND_FIRST;
            else
                op = operand_t'($urandom_range(0, 1));
            if (op == OPERAND_FIRST)
            begin
                ia++;
                last = (ia == na);
            end
            else
            begin
                ib++;
                last = (ib == nb);
            end
            send_word(make_word(op, rand_coef(), last));
            idle(pick_gap());
            // poke the finished side while the other is still loading
            if ((ia == na) != (ib == nb) && $urandom_range(0, 4) == 0)
            begin
                send_word(make_word((ia == na) ? OPERAND_FIRST : OPERAND_SECOND,
                                    rand_coef(), 1'($urandom_range(0, 1))));
                idle(pick_gap());
            end
        end
    endtask

    initial
    begin
        sb      = new();
        steady  = 1'b0;
        counted = 0;
        rst_n   = 1'b0;
        push    = 1'b0;
        item    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(make_word(OPERAND_FIRST, COEF_MIN, 1'b1));
        send_word(make_word(OPERAND_SECOND, COEF_MIN, 1'b1));
        idle(2);
        send_word(make_word(OPERAND_SECOND, COEF_MAX, 1'b1));
        send_word(make_word(OPERAND_SECOND, 64'sd5, 1'b1));
        send_word(make_word(OPERAND_FIRST, -64'sd1, 1'b1));
        idle(1);
        for (int i = 0; i < 17; i++)
            send_word(make_word(OPERAND_FIRST, (i % 2) ? COEF_MAX : COEF_MIN, i == 16));
        send_word(make_word(OPERAND_SECOND, {$urandom, $urandom}, 1'b1));
        idle(3);

        run_pair(MAX_TERMS, MAX_TERMS);
        while (counted < 150)
        begin
            steady = ($urandom_range(0, 4) == 0);
            run_pair(pick_size(), pick_size());
        end
        steady = 1'b0;
        idle(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        pop  = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                pop = 1'b0;
                hold--;
            end
            else
            begin
                pop = 1'b1;
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                sb.check_product(result);
                hold = pick_gap();
            end
        end
    end

endmodule
